// ----- sv/record_gate_timestamp_rebase_defines.svh -----
// Assertion macros for the record gate timestamp rebase block.
// Used by the top level; no other dependencies.
`ifndef RECORD_GATE_TIMESTAMP_REBASE_DEFINES_SVH
`define RECORD_GATE_TIMESTAMP_REBASE_DEFINES_SVH

// same-cycle implication
`define RGTR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RGTR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/rgtr_pkg.sv -----
// Shared types and constants for the record gate timestamp rebase block.
// No dependencies.
`timescale 1ns / 1ps

package rgtr_pkg;

   localparam logic [2:0] STREAM_VIDEO = 3'd0;
   localparam logic [2:0] MAX_STREAM   = 3'd6;

   typedef enum logic [2:0] {
      KIND_PACKET = 3'd0,
      KIND_START  = 3'd1,
      KIND_PAUSE  = 3'd2,
      KIND_RESUME = 3'd3,
      KIND_STOP   = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_WRITTEN    = 3'd0,
      ST_DONE       = 3'd1,
      ST_REFUSED    = 3'd2,
      ST_IDLE_DROP  = 3'd3,
      ST_PAUSED     = 3'd4,
      ST_AWAIT_KEY  = 3'd5,
      ST_NO_OUTPUT  = 3'd6,
      ST_BAD_STREAM = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'b001,
      MODE_REC    = 3'b010,
      MODE_PAUSED = 3'b100
   } mode_type;

   typedef enum logic [0:0] {
      REG_VIDEO_CONFIGURED = 1'b0,
      REG_AUDIO_MASK       = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic       video_configured;
      logic [6:0] audio_stream_mask;
   } cfg_type;

   typedef struct packed {
      logic write_en;
      logic mark_en;
      logic clear_all;
   } stream_cmd_type;

   typedef struct packed {
      logic anchor_valid;
      logic mark_valid;
   } stream_view_type;

endpackage

// ----- sv/rgtr_csr.sv -----
// Configuration registers behind the APB-style port.
// Depends on rgtr_pkg.
`timescale 1ns / 1ps

module rgtr_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output rgtr_pkg::cfg_type cfg
);
   import rgtr_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   csr_reg_type reg_sel;

   assign reg_sel = csr_reg_type'(paddr[2]);
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite && pready) begin
         case (reg_sel)
            REG_VIDEO_CONFIGURED: cfg_in.video_configured  = pwdata[0];
            REG_AUDIO_MASK:       cfg_in.audio_stream_mask = pwdata[6:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_VIDEO_CONFIGURED: prdata = {31'd0, cfg_ff.video_configured};
         REG_AUDIO_MASK:       prdata = {25'd0, cfg_ff.audio_stream_mask};
         default:              prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- sv/rgtr_streams.sv -----
// Per-stream anchor, pause mark and running offset storage with offset update.
// Offsets are kept as anchor plus paused total; a pause mark also stores offset minus mark.
// Depends on rgtr_pkg.
`timescale 1ns / 1ps

module rgtr_streams #(
   parameter  int NUM_STREAMS = 7,
   localparam int SW          = $clog2(NUM_STREAMS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rgtr_pkg::stream_cmd_type cmd,
   input  logic [SW-1:0]            sel,
   input  logic [63:0]              pts,
   input  logic [63:0]              dts,
   output rgtr_pkg::stream_view_type view,
   output logic [63:0]              pts_offset,
   output logic [63:0]              dts_offset
);
   import rgtr_pkg::*;

   logic [NUM_STREAMS-1:0] anchor_valid_ff, anchor_valid_in;
   logic [NUM_STREAMS-1:0] mark_valid_ff, mark_valid_in;
   logic [63:0]            offset_pts_ff [NUM_STREAMS];
   logic [63:0]            offset_dts_ff [NUM_STREAMS];
   logic [63:0]            mark_pts_ff   [NUM_STREAMS];
   logic [63:0]            rebase_pts_ff [NUM_STREAMS];
   logic [63:0]            rebase_dts_ff [NUM_STREAMS];
   logic                   gap_pos;

   assign view.anchor_valid = anchor_valid_ff[sel];
   assign view.mark_valid   = mark_valid_ff[sel];
   assign gap_pos           = $signed(pts) > $signed(mark_pts_ff[sel]);

   always_comb begin
      if (!view.anchor_valid) begin
         pts_offset = pts;
         dts_offset = dts;
      end else if (view.mark_valid && gap_pos) begin
         pts_offset = rebase_pts_ff[sel] + pts;
         dts_offset = rebase_dts_ff[sel] + pts;
      end else begin
         pts_offset = offset_pts_ff[sel];
         dts_offset = offset_dts_ff[sel];
      end
   end

   always_comb begin
      anchor_valid_in = anchor_valid_ff;
      mark_valid_in   = mark_valid_ff;
      if (cmd.clear_all) begin
         anchor_valid_in = '0;
         mark_valid_in   = '0;
      end else if (cmd.write_en) begin
         anchor_valid_in[sel] = 1'b1;
         mark_valid_in[sel]   = 1'b0;
      end else if (cmd.mark_en) begin
         mark_valid_in[sel] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_valid_ff <= '0;
         mark_valid_ff   <= '0;
      end else begin
         anchor_valid_ff <= anchor_valid_in;
         mark_valid_ff   <= mark_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_en && !cmd.clear_all) begin
         offset_pts_ff[sel] <= pts_offset;
         offset_dts_ff[sel] <= dts_offset;
      end
      if (cmd.mark_en && !cmd.clear_all) begin
         mark_pts_ff[sel]   <= pts;
         rebase_pts_ff[sel] <= offset_pts_ff[sel] - pts;
         rebase_dts_ff[sel] <= offset_dts_ff[sel] - pts;
      end
   end

endmodule

// ----- sv/record_gate_timestamp_rebase.sv -----
// Channel  | Direction | Word
// req      | in        | kind, stream_id, pts, dts, keyframe
// rsp      | out       | accepted, status, out_stream, pts_offset, dts_offset, had_output
// csr      | in/out    | APB-style register access, two registers
// One word per cycle unless rsp_stall holds; results leave through the result register.
// Each word is decided by logic between the input register and the result register.
// Reset clears mode, session flags, stream valid bits and the configuration.
// A stalled result holds the input register; req_stall rises only when both are full.
// Top level of the record gate; depends on rgtr_pkg, rgtr_csr, rgtr_streams.
`timescale 1ns / 1ps
`include "record_gate_timestamp_rebase_defines.svh"

module record_gate_timestamp_rebase #(
   parameter int NUM_STREAMS = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [2:0]  req_stream_id,
   input  logic [63:0] req_pts,
   input  logic [63:0] req_dts,
   input  logic        req_keyframe,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_out_stream,
   output logic [63:0] rsp_pts_offset,
   output logic [63:0] rsp_dts_offset,
   output logic        rsp_had_output,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import rgtr_pkg::*;

   localparam int SW = $clog2(NUM_STREAMS);
   localparam int IW = (SW + 1 > 3) ? SW + 1 : 3;

   cfg_type         cfg;
   stream_cmd_type  cmd;
   stream_view_type view;
   logic [63:0]     new_pts_offset, new_dts_offset;

   logic        in_valid_ff;
   logic [2:0]  in_kind_ff, in_stream_ff;
   logic [63:0] in_pts_ff, in_dts_ff;
   logic        in_key_ff;

   logic        rsp_valid_ff;
   logic        rsp_accepted_ff, rsp_accepted_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [2:0]  rsp_stream_ff, rsp_stream_in;
   logic [63:0] rsp_pts_ff, rsp_pts_in;
   logic [63:0] rsp_dts_ff, rsp_dts_in;
   logic        rsp_had_ff, rsp_had_in;

   mode_type mode_ff, mode_in;
   logic     started_ff, started_in;
   logic     resume_wait_ff, resume_wait_in;
   logic     any_written_ff, any_written_in;

   logic          advance, fire;
   logic [IW-1:0] idx_ext;
   logic          idx_valid, key_ok, mask_ok;
   logic [SW-1:0] sel;
   logic [7:0]    mask_ext;
   logic          rsp_written;

   rgtr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rgtr_streams #(.NUM_STREAMS(NUM_STREAMS)) u_streams (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sel        (sel),
      .pts        (in_pts_ff),
      .dts        (in_dts_ff),
      .view       (view),
      .pts_offset (new_pts_offset),
      .dts_offset (new_dts_offset)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign idx_ext   = IW'(in_stream_ff);
   assign idx_valid = (idx_ext < IW'(NUM_STREAMS)) && (in_stream_ff <= MAX_STREAM);
   assign sel       = idx_valid ? idx_ext[SW-1:0] : '0;
   assign key_ok    = (in_stream_ff == STREAM_VIDEO) && in_key_ff;
   assign mask_ext  = {1'b0, cfg.audio_stream_mask};
   assign mask_ok   = (in_stream_ff == STREAM_VIDEO) || mask_ext[in_stream_ff];

   always_comb begin
      mode_in         = mode_ff;
      started_in      = started_ff;
      resume_wait_in  = resume_wait_ff;
      any_written_in  = any_written_ff;
      cmd             = '0;
      rsp_status_in   = ST_REFUSED;
      rsp_stream_in   = 3'd0;
      rsp_pts_in      = 64'd0;
      rsp_dts_in      = 64'd0;
      rsp_had_in      = 1'b0;
      case (kind_type'(in_kind_ff))
         KIND_PACKET: begin
            case (mode_ff)
               MODE_IDLE: rsp_status_in = ST_IDLE_DROP;
               MODE_PAUSED: begin
                  rsp_status_in = ST_PAUSED;
                  cmd.mark_en   = idx_valid && view.anchor_valid && !view.mark_valid;
               end
               MODE_REC: begin
                  if ((!started_ff || resume_wait_ff) && !key_ok) begin
                     rsp_status_in = ST_AWAIT_KEY;
                  end else begin
                     if (key_ok) begin
                        started_in     = 1'b1;
                        resume_wait_in = 1'b0;
                     end
                     if (!cfg.video_configured) begin
                        rsp_status_in = ST_NO_OUTPUT;
                     end else if (!idx_valid || !mask_ok) begin
                        rsp_status_in = ST_BAD_STREAM;
                     end else begin
                        rsp_status_in  = ST_WRITTEN;
                        cmd.write_en   = 1'b1;
                        any_written_in = 1'b1;
                        rsp_stream_in  = in_stream_ff;
                        rsp_pts_in     = new_pts_offset;
                        rsp_dts_in     = new_dts_offset;
                     end
                  end
               end
               default: rsp_status_in = ST_REFUSED;
            endcase
         end
         KIND_START: begin
            if (mode_ff == MODE_IDLE) begin
               mode_in       = MODE_REC;
               rsp_status_in = ST_DONE;
            end
         end
         KIND_PAUSE: begin
            if (mode_ff == MODE_REC) begin
               mode_in       = MODE_PAUSED;
               rsp_status_in = ST_DONE;
            end
         end
         KIND_RESUME: begin
            if (mode_ff == MODE_PAUSED) begin
               mode_in        = MODE_REC;
               resume_wait_in = 1'b1;
               rsp_status_in  = ST_DONE;
            end
         end
         KIND_STOP: begin
            if (mode_ff != MODE_IDLE) begin
               rsp_had_in     = any_written_ff;
               mode_in        = MODE_IDLE;
               started_in     = 1'b0;
               resume_wait_in = 1'b0;
               any_written_in = 1'b0;
               cmd.clear_all  = 1'b1;
               rsp_status_in  = ST_DONE;
            end
         end
         default: rsp_status_in = ST_REFUSED;
      endcase
      rsp_accepted_in = (rsp_status_in == ST_DONE) || (rsp_status_in == ST_WRITTEN);
      if (!fire) begin
         cmd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         mode_ff        <= MODE_IDLE;
         started_ff     <= 1'b0;
         resume_wait_ff <= 1'b0;
         any_written_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            mode_ff        <= mode_in;
            started_ff     <= started_in;
            resume_wait_ff <= resume_wait_in;
            any_written_ff <= any_written_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_kind_ff   <= req_kind;
         in_stream_ff <= req_stream_id;
         in_pts_ff    <= req_pts;
         in_dts_ff    <= req_dts;
         in_key_ff    <= req_keyframe;
      end
      if (fire) begin
         rsp_accepted_ff <= rsp_accepted_in;
         rsp_status_ff   <= rsp_status_in;
         rsp_stream_ff   <= rsp_stream_in;
         rsp_pts_ff      <= rsp_pts_in;
         rsp_dts_ff      <= rsp_dts_in;
         rsp_had_ff      <= rsp_had_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = rsp_accepted_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_stream = rsp_stream_ff;
   assign rsp_pts_offset = rsp_pts_ff;
   assign rsp_dts_offset = rsp_dts_ff;
   assign rsp_had_output = rsp_had_ff;

   assign rsp_written = rsp_valid_ff && (rsp_status_ff == ST_WRITTEN);

   `RGTR_ASSERT_NOW(a_wr_key, rsp_written, started_ff && any_written_ff, "write before key")
   `RGTR_ASSERT_NOW(a_wait_mode, resume_wait_ff, mode_ff != MODE_IDLE, "wait while idle")
   `RGTR_ASSERT_NEXT(a_stall_keeps_word, req_stall, in_valid_ff, "input word lost under stall")

endmodule
